// File: hdl/epa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epa_pkg
// Shared widths, constants and stage records of the echo pulse altimeter.
// ----------------------------------------------------------------------------
package epa_pkg;

    localparam int CAP_W      = 16;   // capture count
    localparam int WID_W      = 14;   // accepted pulse width
    localparam int SUM_W      = WID_W + 1;
    localparam int ALT_W      = 16;
    localparam int VEL_W      = 16;

    // floor(x*272/125) as floor(x*ALT_RECIP >> ALT_SHIFT);
    // ALT_RECIP = 272 * ceil(2^31/125), exact for every 15-bit sum
    localparam int           ALT_SHIFT  = 31;
    localparam int           RECIP_W    = 33;
    localparam int           PROD_W     = SUM_W + RECIP_W;
    localparam int           ALT_FULL_W = PROD_W - ALT_SHIFT;
    localparam logic [RECIP_W-1:0] ALT_RECIP = 33'd4672924640;

    localparam logic [CAP_W-1:0] WRAP_BASE  = 16'hFFFF;
    localparam logic [WID_W-1:0] THRESH_RST = 14'd10000;
    localparam logic [ALT_W-1:0] ALT_MAX    = 16'hFFFF;

    // registered edge event
    typedef struct packed {
        logic             valid;
        logic             pin_level;
        logic [CAP_W-1:0] capture_count;
    } t_edge_evt;

    // after width measurement and rejection
    typedef struct packed {
        logic             valid;
        logic [WID_W-1:0] acc;
        logic             rej;
        logic [SUM_W-1:0] sum;
    } t_width_res;

    // after altitude scaling
    typedef struct packed {
        logic             valid;
        logic [WID_W-1:0] acc;
        logic             rej;
        logic [ALT_W-1:0] alt;
    } t_alt_res;

    // final result
    typedef struct packed {
        logic                    valid;
        logic [WID_W-1:0]        pulse_width;
        logic                    rejected;
        logic [ALT_W-1:0]        altitude;
        logic signed [VEL_W-1:0] velocity;
    } t_result;

endpackage

// File: hdl/epa_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epa_in_if / epa_out_if
// Valid/ready channels for edge events and measurement results.
// ----------------------------------------------------------------------------
interface epa_in_if;
    logic        valid;
    logic        ready;
    logic        pin_level;
    logic [15:0] capture_count;

    modport source (output valid, output pin_level, output capture_count, input ready);
    modport sink   (input valid, input pin_level, input capture_count, output ready);
endinterface

interface epa_out_if;
    logic               valid;
    logic               ready;
    logic [13:0]        pulse_width;
    logic               rejected;
    logic [15:0]        altitude;
    logic signed [15:0] velocity;

    modport source (output valid, output pulse_width, output rejected, output altitude,
                    output velocity, input ready);
    modport sink   (input valid, input pulse_width, input rejected, input altitude,
                    input velocity, output ready);
endinterface

// File: hdl/echo_pulse_altimeter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_pulse_altimeter_unit
// Ultrasonic echo pulse width ranging with outlier rejection.
// ----------------------------------------------------------------------------
// One edge event is taken per cycle while the output is not stalled. A
// falling edge's result passes from the input register, loaded by its
// transfer, through the width, altitude multiply and velocity stages, the
// last one into the output register; a rising edge yields no result. All
// stages advance together whenever the output register is empty or its
// result is being taken, so a stall at the output holds the whole pipeline
// and drops input ready. The reject threshold resets to 10000; the user must
// write it only while no event is in flight; the block does not enforce it.
module echo_pulse_altimeter_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [epa_pkg::WID_W-1:0] i_cfg_wdata,
    epa_in_if.sink                    i_in,
    epa_out_if.source                 o_out
);
    import epa_pkg::*;

    logic [WID_W-1:0] r_threshold;
    logic             adv;
    t_edge_evt        evt;
    t_width_res       width_res;
    t_alt_res         alt_res;
    t_result          result;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RST;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    // pipeline advance
    assign adv        = !result.valid || o_out.ready;
    assign i_in.ready = adv;

    assign evt.valid         = i_in.valid;
    assign evt.pin_level     = i_in.pin_level;
    assign evt.capture_count = i_in.capture_count;

    epa_edge u_edge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_thresh (r_threshold),
        .i_evt    (evt),
        .o_res    (width_res)
    );

    epa_alt u_alt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_res   (width_res),
        .o_res   (alt_res)
    );

    epa_vel u_vel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_res   (alt_res),
        .o_res   (result)
    );

    assign o_out.valid       = result.valid;
    assign o_out.pulse_width = result.pulse_width;
    assign o_out.rejected    = result.rejected;
    assign o_out.altitude    = result.altitude;
    assign o_out.velocity    = result.velocity;

    // a waiting result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(result))
        else $error("waiting result changed before transfer");

    // input ready follows the output side
    a_ready_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready == (!o_out.valid || o_out.ready))
        else $error("input ready out of step with output");

    // checks that threshold writes come only while the output is idle
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> !o_out.valid)
        else $error("threshold written during measurement");

endmodule

// File: hdl/epa_edge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epa_edge
// Input register, echo width measurement and outlier rejection.
// ----------------------------------------------------------------------------
module epa_edge (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic [epa_pkg::WID_W-1:0]  i_thresh,
    input  epa_pkg::t_edge_evt         i_evt,
    output epa_pkg::t_width_res        o_res
);
    import epa_pkg::*;

    t_edge_evt        r_evt;
    t_width_res       r_res;
    t_width_res       n_res;
    logic [CAP_W-1:0] r_rise;
    logic [WID_W-1:0] r_last_good;
    logic [WID_W-1:0] r_prev_width;
    logic [CAP_W-1:0] width;
    logic             rej;
    logic [WID_W-1:0] acc;

    // width with the one-short wrap correction
    always_comb begin
        if (r_rise > r_evt.capture_count) begin
            width = WRAP_BASE - r_rise + r_evt.capture_count;
        end else begin
            width = r_evt.capture_count - r_rise;
        end
        rej = width > {{(CAP_W-WID_W){1'b0}}, i_thresh};
        acc = rej ? r_last_good : width[WID_W-1:0];
        n_res.valid = r_evt.valid && !r_evt.pin_level;
        n_res.acc   = acc;
        n_res.rej   = rej;
        n_res.sum   = {1'b0, acc} + {1'b0, r_prev_width};
    end

    // input register and stage output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_evt.valid <= 1'b0;
            r_res.valid <= 1'b0;
        end else if (i_adv) begin
            r_evt.valid <= i_evt.valid;
            r_res.valid <= n_res.valid;
        end
        if (i_adv) begin
            r_evt.pin_level     <= i_evt.pin_level;
            r_evt.capture_count <= i_evt.capture_count;
            r_res.acc           <= n_res.acc;
            r_res.rej           <= n_res.rej;
            r_res.sum           <= n_res.sum;
        end
    end

    // edge state: rise capture, last good and previous width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise       <= '0;
            r_last_good  <= '0;
            r_prev_width <= '0;
        end else if (i_adv && r_evt.valid) begin
            if (r_evt.pin_level) begin
                r_rise <= r_evt.capture_count;
            end else begin
                if (!rej) begin
                    r_last_good <= acc;
                end
                r_prev_width <= acc;
            end
        end
    end

    assign o_res = r_res;

    // the width just issued is always the current last good width
    a_acc_last_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res.valid |-> r_res.acc == r_last_good)
        else $error("issued width differs from last good width");

    // widths of consecutive falling edges chain through the sum
    a_prev_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res.valid |-> r_prev_width == r_res.acc)
        else $error("previous width not tracking issued width");

endmodule

// File: hdl/epa_alt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epa_alt
// Altitude scaling: floor(sum*272/125) by reciprocal multiply, saturated.
// ----------------------------------------------------------------------------
module epa_alt (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  epa_pkg::t_width_res  i_res,
    output epa_pkg::t_alt_res    o_res
);
    import epa_pkg::*;

    t_alt_res              r_res;
    logic [PROD_W-1:0]     prod;
    logic [ALT_FULL_W-1:0] alt_full;
    logic [ALT_W-1:0]      alt;

    // constant multiply, then clamp to 16 bits
    always_comb begin
        prod     = PROD_W'(i_res.sum) * PROD_W'(ALT_RECIP);
        alt_full = prod[PROD_W-1:ALT_SHIFT];
        if (alt_full > ALT_FULL_W'(ALT_MAX)) begin
            alt = ALT_MAX;
        end else begin
            alt = alt_full[ALT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else if (i_adv) begin
            r_res.valid <= i_res.valid;
        end
        if (i_adv) begin
            r_res.acc <= i_res.acc;
            r_res.rej <= i_res.rej;
            r_res.alt <= alt;
        end
    end

    assign o_res = r_res;

    // a stalled pipeline holds this stage
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_res))
        else $error("altitude stage changed during stall");

endmodule

// File: hdl/epa_vel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epa_vel
// Velocity term: two halved altitude differences averaged; result register.
// ----------------------------------------------------------------------------
module epa_vel (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  epa_pkg::t_alt_res  i_res,
    output epa_pkg::t_result   o_res
);
    import epa_pkg::*;

    t_result                 r_out;
    logic [ALT_W-1:0]        r_prev_alt;
    logic signed [VEL_W-1:0] r_prev_term;
    logic signed [ALT_W:0]   diff;
    logic signed [VEL_W-1:0] term;
    logic signed [VEL_W:0]   tsum;

    // arithmetic halving is a drop of the low bit
    always_comb begin
        diff = $signed({1'b0, i_res.alt}) - $signed({1'b0, r_prev_alt});
        term = diff[ALT_W:1];
        tsum = {term[VEL_W-1], term} + {r_prev_term[VEL_W-1], r_prev_term};
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (i_adv) begin
            r_out.valid <= i_res.valid;
        end
        if (i_adv) begin
            r_out.pulse_width <= i_res.acc;
            r_out.rejected    <= i_res.rej;
            r_out.altitude    <= i_res.alt;
            r_out.velocity    <= tsum[VEL_W:1];
        end
    end

    // previous altitude and term
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_alt  <= '0;
            r_prev_term <= '0;
        end else if (i_adv && i_res.valid) begin
            r_prev_alt  <= i_res.alt;
            r_prev_term <= term;
        end
    end

    assign o_res = r_out;

    // the altitude on the output is the one the next difference uses
    a_prev_alt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out.valid |-> r_prev_alt == r_out.altitude)
        else $error("previous altitude not tracking output");

endmodule
